FILE: rtl/lcfc_pkg.sv
// ============================================================================
// lcfc_pkg
// Types and constants shared by the load command frame checker.
// ============================================================================
package lcfc_pkg;

    localparam int FRAME_BYTES = 8;
    localparam int POS_W       = $clog2(FRAME_BYTES);

    localparam logic [POS_W-1:0] POS_CMD  = POS_W'(1);
    localparam logic [POS_W-1:0] POS_MODE = POS_W'(2);
    localparam logic [POS_W-1:0] POS_VHI  = POS_W'(3);
    localparam logic [POS_W-1:0] POS_VLO  = POS_W'(4);
    localparam logic [POS_W-1:0] POS_LAST = POS_W'(FRAME_BYTES - 1);

    // command byte markers
    localparam logic [7:0] CMD_ERR_LENGTH   = 8'hFF;
    localparam logic [7:0] CMD_ERR_CHECKSUM = 8'hFE;
    localparam logic [7:0] CMD_ERR_EMERG    = 8'hFD;
    localparam logic [7:0] CMD_ERR_BUSY     = 8'hFC;
    localparam logic [7:0] CMD_SET          = 8'h06;

    // reply codes
    localparam logic [7:0] REPLY_NONE      = 8'h00;
    localparam logic [7:0] REPLY_LENGTH    = 8'hFF;
    localparam logic [7:0] REPLY_CHECKSUM  = 8'hFE;
    localparam logic [7:0] REPLY_EMERG     = 8'hFD;
    localparam logic [7:0] REPLY_BUSY      = 8'hFC;
    localparam logic [7:0] REPLY_MISMATCH  = 8'hF9;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_LENGTH    = 3'd1,
        ST_CHECKSUM  = 3'd2,
        ST_EMERGENCY = 3'd3,
        ST_BUSY      = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        MODE_IDLE    = 2'd0,
        MODE_CURRENT = 2'd1,
        MODE_POWER   = 2'd2,
        MODE_RESIST  = 2'd3
    } t_mode;

    // completed frame as seen by the decoder
    typedef struct packed {
        logic       done;
        logic       sum_ok;
        logic [7:0] cmd;
        logic [7:0] mode;
        logic [7:0] val_hi;
        logic [7:0] val_lo;
    } t_frame;

    typedef struct packed {
        t_status     status;
        t_mode       mode;
        logic [15:0] setpoint;
        logic        mismatch;
        logic [7:0]  reply;
    } t_result;

endpackage

FILE: rtl/lcfc_if.sv
// ============================================================================
// lcfc_if
// Valid/ready channels for received bytes and frame results.
// ============================================================================
interface lcfc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       restart;

    modport source (output valid, output rx_byte, output restart, input ready);
    modport sink   (input valid, input rx_byte, input restart, output ready);
endinterface

interface lcfc_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  frame_status;
    logic [1:0]  load_mode;
    logic [15:0] setpoint_milli;
    logic        mode_mismatch;
    logic [7:0]  reply_code;

    modport source (output valid, output frame_status, output load_mode,
                    output setpoint_milli, output mode_mismatch, output reply_code,
                    input ready);
    modport sink   (input valid, input frame_status, input load_mode,
                    input setpoint_milli, input mode_mismatch, input reply_code,
                    output ready);
endinterface

FILE: rtl/lcfc_frame_acc.sv
// ============================================================================
// lcfc_frame_acc
// Byte position, running checksum and stored frame bytes 1 to 4.
// ============================================================================
module lcfc_frame_acc (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_xfer,
    input  logic [7:0]      i_rx_byte,
    input  logic            i_restart,
    output logic            o_at_last,
    output lcfc_pkg::t_frame o_frame
);
    import lcfc_pkg::*;

    logic [POS_W-1:0] r_pos, n_pos;
    logic [7:0]       r_sum, n_sum;
    logic [7:0]       r_cmd, r_mode, r_vhi, r_vlo;

    logic [POS_W-1:0] w_pos;
    logic [7:0]       w_sum;
    logic             w_last;

    // restart clears position and sum before the byte is counted
    assign w_pos  = i_restart ? '0 : r_pos;
    assign w_sum  = i_restart ? '0 : r_sum;
    assign w_last = (w_pos == POS_LAST);

    always_comb begin
        n_pos = r_pos;
        n_sum = r_sum;
        if (i_xfer) begin
            if (w_last) begin
                n_pos = '0;
                n_sum = '0;
            end else begin
                n_pos = w_pos + POS_W'(1);
                n_sum = w_sum + i_rx_byte;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
            r_sum <= '0;
        end else begin
            r_pos <= n_pos;
            r_sum <= n_sum;
        end
    end

    // stored bytes need no reset
    always_ff @(posedge i_clk) begin
        if (i_xfer) begin
            case (w_pos)
                POS_CMD:  r_cmd  <= i_rx_byte;
                POS_MODE: r_mode <= i_rx_byte;
                POS_VHI:  r_vhi  <= i_rx_byte;
                POS_VLO:  r_vlo  <= i_rx_byte;
                default: ;
            endcase
        end
    end

    assign o_at_last = (r_pos == POS_LAST);

    always_comb begin
        o_frame.done   = i_xfer && w_last;
        o_frame.sum_ok = (w_sum == i_rx_byte);
        o_frame.cmd    = r_cmd;
        o_frame.mode   = r_mode;
        o_frame.val_hi = r_vhi;
        o_frame.val_lo = r_vlo;
    end

endmodule

FILE: rtl/lcfc_decode.sv
// ============================================================================
// lcfc_decode
// Status, mode, setpoint and reply code of a completed frame.
// ============================================================================
module lcfc_decode (
    input  lcfc_pkg::t_frame  i_frame,
    output lcfc_pkg::t_result o_result
);
    import lcfc_pkg::*;

    logic w_mode_ok;

    // valid mode bytes are 1 to 3
    assign w_mode_ok = (i_frame.mode[7:2] == 6'd0) && (i_frame.mode[1:0] != 2'd0);

    always_comb begin
        o_result.status   = ST_OK;
        o_result.mode     = MODE_IDLE;
        o_result.setpoint = '0;
        o_result.mismatch = 1'b0;
        o_result.reply    = REPLY_NONE;
        if (!i_frame.sum_ok) begin
            o_result.status = ST_CHECKSUM;
            o_result.reply  = REPLY_CHECKSUM;
        end else begin
            case (i_frame.cmd)
                CMD_ERR_LENGTH: begin
                    o_result.status = ST_LENGTH;
                    o_result.reply  = REPLY_LENGTH;
                end
                CMD_ERR_CHECKSUM: begin
                    o_result.status = ST_CHECKSUM;
                    o_result.reply  = REPLY_CHECKSUM;
                end
                CMD_ERR_EMERG: begin
                    o_result.status = ST_EMERGENCY;
                    o_result.reply  = REPLY_EMERG;
                end
                CMD_ERR_BUSY: begin
                    o_result.status = ST_BUSY;
                    o_result.reply  = REPLY_BUSY;
                end
                CMD_SET: begin
                    if (w_mode_ok) begin
                        o_result.mode     = t_mode'(i_frame.mode[1:0]);
                        o_result.setpoint = {i_frame.val_hi, i_frame.val_lo};
                    end else begin
                        o_result.mismatch = 1'b1;
                        o_result.reply    = REPLY_MISMATCH;
                    end
                end
                default: ;
            endcase
        end
    end

endmodule

FILE: rtl/lcfc_out_reg.sv
// ============================================================================
// lcfc_out_reg
// Result register driving the output channel.
// ============================================================================
module lcfc_out_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  lcfc_pkg::t_result i_result,
    lcfc_out_if.source        o_res
);
    import lcfc_pkg::*;

    logic    r_valid;
    t_result r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_res.valid          = r_valid;
    assign o_res.frame_status   = r_result.status;
    assign o_res.load_mode      = r_result.mode;
    assign o_res.setpoint_milli = r_result.setpoint;
    assign o_res.mode_mismatch  = r_result.mismatch;
    assign o_res.reply_code     = r_result.reply;

endmodule

FILE: rtl/load_command_frame_checker.sv
// ============================================================================
// load_command_frame_checker
// Takes the bytes of fixed 8-byte load command frames, one byte per transfer,
// and returns one result per complete frame: status (checksum first, then the
// error markers in byte 1), load mode, setpoint in thousandths and the reply
// code byte. A byte is taken every cycle unless it waits at the checksum
// position; the result leaves from a register in the cycle after the checksum
// byte (byte 7) is taken. Bytes 0 to 6 are taken even while an earlier result
// waits at the output; only a byte arriving at the checksum position waits
// until the result register is free, even when it carries restart. Setting
// restart with a byte drops any partial frame and counts that byte as frame
// byte 0, so a restart on the checksum position gives no result.
// ============================================================================
module load_command_frame_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    lcfc_in_if.sink    i_cmd,
    lcfc_out_if.source o_res
);
    import lcfc_pkg::*;

    logic    w_xfer;
    logic    w_at_last;
    t_frame  w_frame;
    t_result w_result;

    // a byte at the checksum position needs a free result register, restart
    // or not; bytes at other positions never stall
    assign i_cmd.ready = !w_at_last || !o_res.valid || o_res.ready;
    assign w_xfer      = i_cmd.valid && i_cmd.ready;

    lcfc_frame_acc u_acc (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_xfer    (w_xfer),
        .i_rx_byte (i_cmd.rx_byte),
        .i_restart (i_cmd.restart),
        .o_at_last (w_at_last),
        .o_frame   (w_frame)
    );

    lcfc_decode u_dec (
        .i_frame  (w_frame),
        .o_result (w_result)
    );

    lcfc_out_reg u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (w_frame.done),
        .i_result (w_result),
        .o_res    (o_res)
    );

    // a completed frame always lands in the result register
    a_done_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_frame.done |=> o_res.valid)
        else $error("completed frame produced no result");

    // a frame never completes over a result that is still waiting
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_frame.done |-> (!o_res.valid || o_res.ready))
        else $error("result overwritten before transfer");

    // mismatch carries its reply and an idle mode
    a_mismatch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && o_res.mode_mismatch |->
            (o_res.reply_code == REPLY_MISMATCH) && (o_res.load_mode == MODE_IDLE))
        else $error("mismatch result inconsistent");

    // idle results carry no setpoint
    a_idle_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && (o_res.load_mode == MODE_IDLE) |-> (o_res.setpoint_milli == 16'd0))
        else $error("idle result with nonzero setpoint");

endmodule
